// File: sv/trcc_pkg.sv
package trcc_pkg;

   localparam int unsigned POS_WIDTH = 3;

   // Byte positions within a record; position 4 covers every later byte
   localparam logic [POS_WIDTH-1:0] POS_FIRST  = 3'd0;
   localparam logic [POS_WIDTH-1:0] POS_SECOND = 3'd1;
   localparam logic [POS_WIDTH-1:0] POS_XOR    = 3'd2;
   localparam logic [POS_WIDTH-1:0] POS_ROT    = 3'd3;
   localparam logic [POS_WIDTH-1:0] POS_BODY   = 3'd4;

   localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
   localparam logic [1:0] KIND_HEADER   = 2'd1;
   localparam logic [1:0] KIND_NUMERIC  = 2'd2;
   localparam logic [1:0] KIND_SYMBOLIC = 2'd3;

   // Leading byte pairs (octal) that name the record kind
   localparam logic [7:0] HEADER_FIRST    = 8'o201;
   localparam logic [7:0] HEADER_SECOND   = 8'o176;
   localparam logic [7:0] NUMERIC_FIRST   = 8'o303;
   localparam logic [7:0] NUMERIC_SECOND  = 8'o074;
   localparam logic [7:0] SYMBOLIC_FIRST  = 8'o347;
   localparam logic [7:0] SYMBOLIC_SECOND = 8'o030;

   typedef struct packed {
      logic [1:0] record_kind;
      logic       checksum_ok;
      logic       short_record;
      logic [7:0] xor_sum;
      logic [7:0] rotate_sum;
   } trcc_result_type;

   function automatic logic [1:0] classify(input logic [7:0] a, input logic [7:0] b);
      logic [1:0] kind;
      kind = KIND_UNKNOWN;
      if (a == HEADER_FIRST && b == HEADER_SECOND) begin
         kind = KIND_HEADER;
      end else if (a == NUMERIC_FIRST && b == NUMERIC_SECOND) begin
         kind = KIND_NUMERIC;
      end else if (a == SYMBOLIC_FIRST && b == SYMBOLIC_SECOND) begin
         kind = KIND_SYMBOLIC;
      end
      return kind;
   endfunction

   function automatic logic [7:0] rotate_right(input logic [7:0] v);
      return {v[0], v[7:1]};
   endfunction

endpackage

// File: sv/trcc_accum.sv
module trcc_accum
   import trcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      data_byte,
   input  logic            end_of_record,
   output trcc_result_type result
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] rot_ff, rot_in;
   logic [7:0] first_nx, second_nx, xor_nx, rot_nx;
   logic       is_short;

   always_comb begin
      first_nx  = first_ff;
      second_nx = second_ff;
      xor_nx    = xor_ff;
      rot_nx    = rot_ff;
      case (pos_ff)
         POS_FIRST:  first_nx  = data_byte;
         POS_SECOND: second_nx = data_byte;
         POS_XOR:    xor_nx    = data_byte;
         POS_ROT:    rot_nx    = data_byte;
         default: begin
            xor_nx = xor_ff ^ data_byte;
            rot_nx = rotate_right(rot_ff ^ data_byte);
         end
      endcase
   end

   assign is_short = (pos_ff < POS_ROT);

   always_comb begin
      result.record_kind  = classify(first_nx, second_nx);
      result.short_record = is_short;
      result.checksum_ok  = !is_short && (xor_nx == 8'd0) && (rot_nx == 8'd0);
      result.xor_sum      = xor_nx;
      result.rotate_sum   = rot_nx;
   end

   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      xor_in    = xor_ff;
      rot_in    = rot_ff;
      if (take) begin
         if (end_of_record) begin
            pos_in    = POS_FIRST;
            first_in  = 8'd0;
            second_in = 8'd0;
            xor_in    = 8'd0;
            rot_in    = 8'd0;
         end else begin
            pos_in    = (pos_ff < POS_BODY) ? pos_ff + 3'd1 : pos_ff;
            first_in  = first_nx;
            second_in = second_nx;
            xor_in    = xor_nx;
            rot_in    = rot_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_FIRST;
         first_ff  <= 8'd0;
         second_ff <= 8'd0;
         xor_ff    <= 8'd0;
         rot_ff    <= 8'd0;
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         xor_ff    <= xor_in;
         rot_ff    <= rot_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_BODY)
      else $error("byte position beyond saturation");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && end_of_record |=> pos_ff == POS_FIRST && xor_ff == 8'd0 && rot_ff == 8'd0)
      else $error("record state not cleared after last byte");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      take && !end_of_record && pos_ff < POS_BODY |=> pos_ff == $past(pos_ff) + 3'd1)
      else $error("byte position did not advance");

endmodule

// File: sv/trcc_out_reg.sv
module trcc_out_reg
   import trcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  trcc_result_type result,
   output logic            free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output trcc_result_type held
);

   logic            valid_ff, valid_in;
   trcc_result_type data_ff, data_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_short_fails: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.short_record |-> !data_ff.checksum_ok)
      else $error("short record reported as passing");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("pending result overwritten");

endmodule

// File: sv/tape_record_checksum_checker_unit.sv
// Tape record checksum checker: one record byte per req transfer.
// Throughput: one byte per cycle, sustained while rsp_ready stays high.
// The result of a last byte is registered and appears on rsp in the cycle after its transfer.
// Non-last bytes only update the record state and produce no rsp transfer.
// Reset (synchronous, active high) clears the record state and drops rsp_valid.
module tape_record_checksum_checker_unit
   import trcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_record,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_record_kind,
   output logic       rsp_checksum_ok,
   output logic       rsp_short_record,
   output logic [7:0] rsp_xor_sum,
   output logic [7:0] rsp_rotate_sum
);

   logic            take;
   logic            out_free;
   trcc_result_type result;
   trcc_result_type held;

   // Accept whenever the result register is empty or draining this cycle;
   // a result held while rsp_ready is low stalls every byte until it drains.
   assign req_ready = out_free;
   assign take      = req_valid && req_ready;

   // Record state: leading bytes, position and the two running sums
   trcc_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_data_byte),
      .end_of_record (req_end_of_record),
      .result        (result)
   );

   // Result register: load only on the transfer of a record's last byte
   trcc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take && req_end_of_record),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .held      (held)
   );

   assign rsp_record_kind  = held.record_kind;
   assign rsp_checksum_ok  = held.checksum_ok;
   assign rsp_short_record = held.short_record;
   assign rsp_xor_sum      = held.xor_sum;
   assign rsp_rotate_sum   = held.rotate_sum;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import trcc_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   // Bytes to push through in the random phase
   localparam int BYTE_TARGET   = 1800;
   // Worst case is roughly 2000 bytes with random idle gaps; leave a wide margin
   localparam int CYCLE_LIMIT   = 500000;
   // Result shows up in the cycle after the last byte; settle time on top of that
   localparam int SETTLE_CYCLES = 8;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte     = 8'h00;
   logic       req_end_of_record = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [1:0] rsp_record_kind;
   logic       rsp_checksum_ok;
   logic       rsp_short_record;
   logic [7:0] rsp_xor_sum;
   logic [7:0] rsp_rotate_sum;

   tape_record_checksum_checker_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_record (req_end_of_record),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_short_record  (rsp_short_record),
      .rsp_xor_sum       (rsp_xor_sum),
      .rsp_rotate_sum    (rsp_rotate_sum)
   );

   // Shadow copy of the record state, advanced on every accepted byte
   logic [2:0] byte_count;
   logic [7:0] lead_a;
   logic [7:0] lead_b;
   logic [7:0] sum_xor;
   logic [7:0] sum_rot;

   // Record summaries that the block still owes us, oldest first
   trcc_result_type pending_results[$];

   // Gap switches: when low that side never idles
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   int mismatches      = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int good_results    = 0;
   int short_results   = 0;
   int cycle_count     = 0;

   // Map the two leading bytes onto a record kind
   function automatic logic [1:0] kind_of(input logic [7:0] a, input logic [7:0] b);
      if (a == HEADER_FIRST && b == HEADER_SECOND) return KIND_HEADER;
      if (a == NUMERIC_FIRST && b == NUMERIC_SECOND) return KIND_NUMERIC;
      if (a == SYMBOLIC_FIRST && b == SYMBOLIC_SECOND) return KIND_SYMBOLIC;
      return KIND_UNKNOWN;
   endfunction

   function automatic int draw_wait(input bit enabled);
      if (!enabled) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic clear_record();
      byte_count = POS_FIRST;
      lead_a     = 8'h00;
      lead_b     = 8'h00;
      sum_xor    = 8'h00;
      sum_rot    = 8'h00;
   endtask

   // Advance the shadow state by one byte; queue a summary on the last one
   task automatic predict_byte(input logic [7:0] b, input logic last);
      trcc_result_type want;
      logic [7:0]      mixed;
      case (byte_count)
         POS_FIRST:  lead_a  = b;
         POS_SECOND: lead_b  = b;
         POS_XOR:    sum_xor = b;
         POS_ROT:    sum_rot = b;
         default: begin
            // fold into both sums, then rotate the second one right
            mixed   = sum_rot ^ b;
            sum_xor = sum_xor ^ b;
            sum_rot = {mixed[0], mixed[7:1]};
         end
      endcase
      if (!last) begin
         if (byte_count != POS_BODY) byte_count = byte_count + 3'd1;
      end else begin
         // byte_count holds the index of this last byte, saturated at POS_BODY
         want.record_kind  = kind_of(lead_a, lead_b);
         want.short_record = (byte_count < POS_ROT);
         want.checksum_ok  = !want.short_record && sum_xor == 8'h00 && sum_rot == 8'h00;
         want.xor_sum      = sum_xor;
         want.rotate_sum   = sum_rot;
         pending_results.push_back(want);
         clear_record();
      end
   endtask

   // Drive one byte and hold it until transferred. Called at a rising edge;
   // returns at the edge of the transfer with req_valid still high.
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = draw_wait(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_record <= last;
      do @(posedge clock); while (!req_ready);
      predict_byte(data, last);
      bytes_sent++;
   endtask

   task automatic send_record(input byte_queue_type rec);
      foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
   endtask

   // Drop valid and hold off until every owed summary has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Build one record. Most are well formed: a known leading pair and sums
   // that cancel to zero, some with one bit flipped; the rest are noise.
   function automatic byte_queue_type make_record();
      byte_queue_type rec;
      logic [15:0] known;
      logic [15:0] lead;
      logic [7:0]  seed;
      logic [7:0]  running;
      logic [7:0]  b;
      int          style;
      int          length;
      int          idx;
      case ($urandom_range(0, 2))
         0:       known = {HEADER_FIRST, HEADER_SECOND};
         1:       known = {NUMERIC_FIRST, NUMERIC_SECOND};
         default: known = {SYMBOLIC_FIRST, SYMBOLIC_SECOND};
      endcase
      case ($urandom_range(0, 7))
         6:       lead = known ^ (16'h0001 << $urandom_range(0, 15));
         7:       lead = 16'($urandom);
         default: lead = known;
      endcase
      style = $urandom_range(0, 9);
      if (style < 7) begin
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(4, 12);
         rec.push_back(lead[15:8]);
         rec.push_back(lead[7:0]);
         if (length == 4) begin
            rec.push_back(8'h00);
            rec.push_back(8'h00);
         end else begin
            // equal seeds keep both sums equal as long as each body byte
            // is the running value or its inverse; the last byte cancels it
            seed = 8'($urandom);
            rec.push_back(seed);
            rec.push_back(seed);
            running = seed;
            for (idx = 5; idx < length; idx++) begin
               b = $urandom_range(0, 1) ? running : ~running;
               rec.push_back(b);
               running = running ^ b;
            end
            rec.push_back(running);
         end
         if (style >= 4) begin
            idx = $urandom_range(0, rec.size() - 1);
            rec[idx] = rec[idx] ^ (8'h01 << $urandom_range(0, 7));
         end
      end else begin
         length = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
         for (idx = 0; idx < length; idx++) begin
            if (idx == 0) rec.push_back(lead[15:8]);
            else if (idx == 1) rec.push_back(lead[7:0]);
            else rec.push_back(8'($urandom));
         end
      end
      return rec;
   endfunction

   // Each kind once, with sums that do and do not cancel (13 bytes)
   task automatic test_leading_pairs();
      send_record('{HEADER_FIRST, HEADER_SECOND, 8'h00, 8'h00});
      send_record('{NUMERIC_FIRST, NUMERIC_SECOND, 8'hFF, 8'h00, 8'hFF});
      send_record('{SYMBOLIC_FIRST, SYMBOLIC_SECOND, 8'h80, 8'h01});
   endtask

   // One, two and three byte records, one with a header pair (6 bytes)
   task automatic test_short_records();
      send_record('{8'hFF});
      send_record('{HEADER_FIRST, HEADER_SECOND});
      send_record('{8'h00, 8'h00, 8'hAA});
   endtask

   // Past the fourth byte the position saturates and the rotate kicks in (6 bytes)
   task automatic test_long_record();
      send_record('{8'h00, 8'hFF, 8'h01, 8'h01, 8'h00, 8'h00});
   endtask

   // Stop feeding mid-run until the result channel has caught up
   task automatic test_drain_pause();
      send_record(make_record());
      wait_for_drain();
      send_record(make_record());
      wait_for_drain();
   endtask

   task automatic test_random_records();
      int start_bytes;
      int record_count;
      start_bytes  = bytes_sent;
      record_count = 0;
      while (bytes_sent - start_bytes < BYTE_TARGET) begin
         // reshuffle idling every 16 records so both sides see busy and quiet stretches
         if (record_count % 16 == 0) begin
            req_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         send_record(make_record());
         record_count++;
         if (record_count % 60 == 0) wait_for_drain();
      end
   endtask

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: give up if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results owed",
                  $time, cycle_count, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Check each transferred result against the oldest owed summary
   always @(posedge clock) begin : check_results
      trcc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected: kind %0d ok %0b short %0b xor %0h rot %0h",
                     $time, rsp_record_kind, rsp_checksum_ok, rsp_short_record,
                     rsp_xor_sum, rsp_rotate_sum);
         end else begin
            want = pending_results.pop_front();
            compare_field("record_kind", 8'(want.record_kind), 8'(rsp_record_kind));
            compare_field("checksum_ok", 8'(want.checksum_ok), 8'(rsp_checksum_ok));
            compare_field("short_record", 8'(want.short_record), 8'(rsp_short_record));
            compare_field("xor_sum", want.xor_sum, rsp_xor_sum);
            compare_field("rotate_sum", want.rotate_sum, rsp_rotate_sum);
            results_checked++;
            if (want.checksum_ok) good_results++;
            if (want.short_record) short_results++;
         end
      end
   end

   // Result side: stall a random number of cycles, then take the next transfer
   initial begin : drive_rsp_ready
      int stall;
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_idle_on);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      clear_record();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_leading_pairs();
      test_short_records();
      test_long_record();
      test_drain_pause();
      test_random_records();

      // Release the input and let the last results come out
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d record bytes; checked %0d record results", bytes_sent, results_checked);
      $display("of which %0d had clean checksums and %0d were short", good_results,
               short_results);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
